// ===== hdl/bdu_pkg.sv =====
// Shared types and constants for the balanced digit unpacker.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdu_pkg;

    // Default parameter values
    localparam int WORD_BITS_DEF      = 64;
    localparam int MAX_DIGIT_BITS_DEF = 32;

    // Fixed field widths
    localparam int IN_W    = 64;
    localparam int EXP_W   = 32;
    localparam int CNT_W   = 25;
    localparam int IDX_W   = 24;
    localparam int DIGIT_W = 32;
    localparam int CSUM_W  = 64;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_EXPONENT    = 1'b0;
    localparam logic REG_DIGIT_COUNT = 1'b1;

    // Reset values of the registers
    localparam logic [EXP_W-1:0] EXPONENT_RST    = EXP_W'(4);
    localparam logic [CNT_W-1:0] DIGIT_COUNT_RST = CNT_W'(2);

    // Divider iteration counter width
    localparam int DIV_CNT_W = $clog2(EXP_W + 1);

    typedef enum logic [1:0] {
        ST_SETUP,
        ST_DIV,
        ST_IDLE,
        ST_DIGIT
    } bdu_state_t;

    // Controller to datapath
    typedef struct packed {
        logic div_start;
        logic restart;
        logic load_word;
        logic save_held;
        logic step;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic exhausted;
        logic last_digit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/bdu_divider.sv =====
// Restoring divider: exponent / digit count, one quotient bit per cycle.
// Depends on bdu_pkg for the field widths.
`default_nettype none

module bdu_divider
    import bdu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [EXP_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [EXP_W-1:0]      quotient,
    output logic [CNT_W-1:0]      remainder
);

    logic [EXP_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       diff;
    logic                 fits;

    // One trial subtraction per cycle
    assign shifted = {rem_reg, quo_reg[EXP_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = shifted >= {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(EXP_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[EXP_W-2:0], fits};
            rem_next = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hdl/bdu_datapath.sv =====
// Datapath: word buffer, digit extraction, balanced carry, cadence and checksum.
// Depends on bdu_pkg and bdu_divider.
`default_nettype none

module bdu_datapath
    import bdu_pkg::*;
#(
    parameter int WORD_BITS      = WORD_BITS_DEF,
    parameter int MAX_DIGIT_BITS = MAX_DIGIT_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_cmd_t          cmd,
    output dp_status_t              status,
    input  wire logic [EXP_W-1:0]   exponent,
    input  wire logic [CNT_W-1:0]   digit_count,
    input  wire logic [IN_W-1:0]    packed_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DIGIT_W-1:0]      digit,
    output logic [IDX_W-1:0]        digit_index,
    output logic                    last,
    output logic                    wrap_carry,
    output logic [CSUM_W-1:0]       word_checksum
);

    localparam int CAP   = (MAX_DIGIT_BITS < WORD_BITS) ? MAX_DIGIT_BITS : WORD_BITS;
    localparam int W_W   = $clog2(CAP + 1);
    localparam int POS_W = $clog2(WORD_BITS + 1);
    localparam int AUX_W = WORD_BITS + 1;

    // Effective digit count (0 and 1 behave as 2)
    logic [CNT_W-1:0] n_eff;
    assign n_eff = (digit_count < CNT_W'(2)) ? CNT_W'(2) : digit_count;

    // Width setup through the divider
    logic             div_done;
    logic [EXP_W-1:0] div_quo;
    logic [CNT_W-1:0] div_rem;

    bdu_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (exponent),
        .divisor   (n_eff),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    logic [W_W-1:0]   ns_reg, ns_next;
    logic [CNT_W-1:0] bb_reg, bb_next;
    logic [CNT_W-1:0] cc_reg, cc_next;

    // Clamp the base width to [2, CAP-1]
    always_comb
    begin
        ns_next = ns_reg;
        bb_next = bb_reg;
        cc_next = cc_reg;
        if (div_done)
        begin
            if (div_quo > EXP_W'(CAP - 1))
                ns_next = W_W'(CAP - 1);
            else if (div_quo < EXP_W'(2))
                ns_next = W_W'(2);
            else
                ns_next = W_W'(div_quo);
            bb_next = div_rem;
            cc_next = n_eff - div_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        ns_reg <= ns_next;
        bb_reg <= bb_next;
        cc_reg <= cc_next;
    end

    // Stream state
    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [WORD_BITS-1:0] held_reg, held_next;
    logic [POS_W-1:0]     bitpos_reg, bitpos_next;
    logic [CNT_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     done_reg, done_next;
    logic                 carry_reg, carry_next;
    logic [CSUM_W-1:0]    csum_reg, csum_next;

    // Digit extraction
    logic                 big;
    logic [W_W-1:0]       w;
    logic [WORD_BITS-1:0] src;
    logic [WORD_BITS-1:0] wmask;
    logic [WORD_BITS-1:0] val;
    logic [AUX_W-1:0]     aux;
    logic [AUX_W-1:0]     full;
    logic                 carry_new;
    logic [AUX_W-1:0]     dig_full;
    logic [POS_W-1:0]     pos_step;
    logic [CNT_W-1:0]     acc_step;
    logic [CNT_W-1:0]     done_inc;
    logic                 is_last;
    logic                 exhausted;

    assign big   = acc_reg >= cc_reg;
    assign w     = big ? ns_reg + W_W'(1) : ns_reg;
    assign src   = (bitpos_reg != '0) ? (held_reg | (word_reg << bitpos_reg))
                                      : (word_reg >> pos_reg);
    assign wmask = ~({WORD_BITS{1'b1}} << w);
    assign val   = src & wmask;

    // Balanced form: reach half range -> subtract full range, carry on
    assign aux       = {1'b0, val} + AUX_W'(carry_reg);
    assign carry_new = |(aux >> (w - W_W'(1)));
    assign full      = AUX_W'(1) << w;
    assign dig_full  = carry_new ? aux - full : aux;

    assign pos_step  = (bitpos_reg != '0) ? POS_W'(w) - bitpos_reg : pos_reg + POS_W'(w);
    assign acc_step  = big ? acc_reg - cc_reg : acc_reg + bb_reg;
    assign done_inc  = done_reg + CNT_W'(1);
    assign is_last   = done_inc >= n_eff;
    assign exhausted = (bitpos_reg == '0) && ((POS_W'(WORD_BITS) - pos_reg) < POS_W'(w));

    // Ones' complement word sum
    logic [CSUM_W:0]   csum_sum;
    logic [CSUM_W-1:0] csum_add;
    assign csum_sum = {1'b0, csum_reg} + {1'b0, CSUM_W'(packed_word[WORD_BITS-1:0])};
    assign csum_add = csum_sum[CSUM_W-1:0] + CSUM_W'(csum_sum[CSUM_W]);

    // Stream state update
    always_comb
    begin
        word_next   = word_reg;
        pos_next    = pos_reg;
        held_next   = held_reg;
        bitpos_next = bitpos_reg;
        acc_next    = acc_reg;
        done_next   = done_reg;
        carry_next  = carry_reg;
        csum_next   = csum_reg;
        if (cmd.restart || (cmd.step && is_last))
        begin
            held_next   = '0;
            bitpos_next = '0;
            acc_next    = n_eff;
            done_next   = '0;
            carry_next  = 1'b0;
            csum_next   = '0;
        end
        else if (cmd.step)
        begin
            pos_next    = pos_step;
            held_next   = '0;
            bitpos_next = '0;
            carry_next  = carry_new;
            done_next   = done_inc;
            acc_next    = (done_inc == n_eff - CNT_W'(1)) ? '0 : acc_step;
        end
        else
        begin
            if (cmd.save_held)
            begin
                held_next   = word_reg >> pos_reg;
                bitpos_next = POS_W'(WORD_BITS) - pos_reg;
            end
            if (cmd.load_word)
            begin
                word_next = packed_word[WORD_BITS-1:0];
                pos_next  = '0;
                csum_next = csum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            held_reg   <= '0;
            bitpos_reg <= '0;
            acc_reg    <= DIGIT_COUNT_RST;
            done_reg   <= '0;
            carry_reg  <= 1'b0;
            csum_reg   <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            held_reg   <= held_next;
            bitpos_reg <= bitpos_next;
            acc_reg    <= acc_next;
            done_reg   <= done_next;
            carry_reg  <= carry_next;
            csum_reg   <= csum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]  digit_reg, digit_next;
    logic [IDX_W-1:0]    index_reg, index_next;
    logic                last_reg, last_next;
    logic                wrap_reg, wrap_next;
    logic [CSUM_W-1:0]   ocsum_reg, ocsum_next;
    logic                out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        digit_next     = digit_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        wrap_next      = wrap_reg;
        ocsum_next     = ocsum_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
            digit_next     = dig_full[DIGIT_W-1:0];
            index_next     = done_reg[IDX_W-1:0];
            last_next      = is_last;
            wrap_next      = is_last && carry_new;
            ocsum_next     = is_last ? csum_reg : '0;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
        index_reg <= index_next;
        last_reg  <= last_next;
        wrap_reg  <= wrap_next;
        ocsum_reg <= ocsum_next;
    end

    assign out_valid     = out_valid_reg;
    assign digit         = digit_reg;
    assign digit_index   = index_reg;
    assign last          = last_reg;
    assign wrap_carry    = wrap_reg;
    assign word_checksum = ocsum_reg;

    assign status.div_done   = div_done;
    assign status.exhausted  = exhausted;
    assign status.last_digit = is_last;
    assign status.out_free   = out_free;

endmodule

`default_nettype wire

// ===== hdl/bdu_ctrl.sv =====
// Controller state machine: width setup, word intake and digit stepping.
// Depends on bdu_pkg for the state and command types.
`default_nettype none

module bdu_ctrl
    import bdu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    bdu_state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_SETUP: state_next = ST_DIV;
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (status.exhausted)
                    state_next = in_valid ? ST_DIGIT : ST_IDLE;
                else if (status.out_free && status.last_digit)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_SETUP;
        endcase
        if (cfg_wr)
            state_next = ST_SETUP;
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_SETUP:
            begin
                cmd.div_start = 1'b1;
                cmd.restart   = 1'b1;
            end
            ST_DIV:
            begin
                in_stall = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.load_word = in_valid;
            end
            ST_DIGIT:
            begin
                if (status.exhausted)
                begin
                    in_stall      = 1'b0;
                    cmd.save_held = 1'b1;
                    cmd.load_word = in_valid;
                end
                else
                begin
                    cmd.step = status.out_free;
                end
            end
            default: in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_SETUP;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/balanced_digit_unpacker.sv =====
// Balanced digit unpacker: top level with the register port.
// Depends on bdu_pkg, bdu_ctrl, bdu_datapath (and bdu_divider below it).
//
// Usage:
//   Input channel (in_valid / in_stall / packed_word) takes 64-bit words of a
//   residue, least significant word first. Output channel (out_valid /
//   out_stall) gives one digit word per transfer: digit, digit_index, last,
//   wrap_carry and word_checksum (the last two only meaningful with last).
//   Registers: exponent at byte 0, digit_count at byte 4. A write restarts
//   the stream and recomputes the digit widths with a bit-serial divider,
//   during which in_stall stays high. Reset does the same.
//   Flow: a word is taken, then its digits leave at one per cycle while the
//   receiver does not stall, each through the output register. Once a word
//   is used up, a further step saves its leftover bits and fetches the next
//   word, so a waiting word is taken without a return to idle. The digit
//   rate is set by the extraction shifter.
//   When the receiver stalls, the held digit stays put and no further digit
//   is formed; the next word can still be taken once the current one is
//   used up. Unused bits of the word that ends a residue are dropped.
`default_nettype none

module balanced_digit_unpacker
    import bdu_pkg::*;
#(
    parameter int WORD_BITS      = WORD_BITS_DEF,
    parameter int MAX_DIGIT_BITS = MAX_DIGIT_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    // Input words
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [IN_W-1:0]    packed_word,
    // Output digits
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [DIGIT_W-1:0]      digit,
    output logic [IDX_W-1:0]        digit_index,
    output logic                    last,
    output logic                    wrap_carry,
    output logic [CSUM_W-1:0]       word_checksum
);

    logic [EXP_W-1:0] exponent_reg, exponent_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Register writes
    always_comb
    begin
        exponent_next = exponent_reg;
        count_next    = count_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_EXPONENT:    exponent_next = pwdata[EXP_W-1:0];
                REG_DIGIT_COUNT: count_next    = pwdata[CNT_W-1:0];
                default:         exponent_next = exponent_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXPONENT_RST;
            count_reg    <= DIGIT_COUNT_RST;
        end
        else
        begin
            exponent_reg <= exponent_next;
            count_reg    <= count_next;
        end
    end

    // Register reads
    always_comb
    begin
        case (paddr[2])
            REG_EXPONENT:    prdata = PDATA_W'(exponent_reg);
            REG_DIGIT_COUNT: prdata = PDATA_W'(count_reg);
            default:         prdata = '0;
        endcase
    end

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bdu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    bdu_datapath #(
        .WORD_BITS      (WORD_BITS),
        .MAX_DIGIT_BITS (MAX_DIGIT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .exponent      (exponent_reg),
        .digit_count   (count_reg),
        .packed_word   (packed_word),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .digit         (digit),
        .digit_index   (digit_index),
        .last          (last),
        .wrap_carry    (wrap_carry),
        .word_checksum (word_checksum)
    );

endmodule

`default_nettype wire
